### sv/qkv_pkg.sv
`timescale 1ns / 1ps

package qkv_pkg;

    // Field widths fixed by the interface
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Item kinds
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_ELEM   = 1'b1;

    // Matrix selects
    localparam logic [1:0] SEL_QUERY = 2'd0;
    localparam logic [1:0] SEL_KEY   = 2'd1;
    localparam logic [1:0] SEL_VALUE = 2'd2;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    // Register indexes
    localparam logic REG_EMBED   = 1'b0;
    localparam logic REG_KEY_DIM = 1'b1;

    // Matrix write enable bit positions
    localparam int WE_Q = 0;
    localparam int WE_K = 1;
    localparam int WE_V = 2;

    typedef struct packed {
        logic                     kind;
        logic [1:0]               matrix_select;
        logic [IDX_W-1:0]         weight_row;
        logic [IDX_W-1:0]         weight_col;
        logic signed [DATA_W-1:0] weight_value;
        logic signed [DATA_W-1:0] x_value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]        column;
        logic signed [ACC_W-1:0] query_sum;
        logic signed [ACC_W-1:0] key_sum;
        logic signed [ACC_W-1:0] value_sum;
        logic                    last;
    } t_out_word;

    // Three sums travelling down the drain chain
    typedef struct packed {
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] k;
        logic signed [ACC_W-1:0] v;
    } t_sums;

    // Control broadcast to every column cell
    typedef struct packed {
        logic [2:0]               wr_en;
        logic [IDX_W-1:0]         wr_col;
        logic signed [DATA_W-1:0] wr_data;
        logic signed [DATA_W-1:0] x;
        logic                     acc_en;
        logic                     close;
        logic                     shift;
    } t_cell_ctl;

    // Zero counts as one, values above the maximum saturate
    function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v, int maxv);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > maxv) begin
            r = CNT_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### sv/qkv_projection_top.sv
`timescale 1ns / 1ps

// Query/key/value projection of embedding rows.
// Input channel (i_in_valid / o_in_stall / i_in_data): a word is either a
// weight write (one entry of the query, key or value matrix) or one element
// of an embedding row, elements in order. Output channel (o_out_valid /
// i_out_stall / o_out_data): at the end of each row, one word per key column,
// column 0 first, with the three 40-bit sums and last on the final column.
// APB port: register 0 (row length) at 0x0, register 1 (key columns) at 0x4.
// Throughput: one input word per cycle while a row streams in. The element
// that closes a row stalls the input until all its results are taken; it
// passes the s1 and s2 stages before its sums load the drain chain, then
// one result per cycle follows while the receiver does not stall.
// The drain is a shift chain through the column cells, one column a cycle.
// A stalled receiver freezes the chain and holds the output word.
// Reset clears accumulators, row position and control and sets both
// registers to 64; the weight memories are not cleared and must be written
// before use.
module qkv_projection_top
    import qkv_pkg::*;
#(
    parameter int MAX_EMBED   = 64,
    parameter int MAX_KEY_DIM = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int EIW = (MAX_EMBED > 1) ? $clog2(MAX_EMBED) : 1;
    localparam logic [CNT_W-1:0] EMBED_RST = clamp_count(CNT_W'(64), MAX_EMBED);
    localparam logic [CNT_W-1:0] KDIM_RST  = clamp_count(CNT_W'(64), MAX_KEY_DIM);

    logic [CNT_W-1:0]         r_embed;
    logic [CNT_W-1:0]         r_kdim;
    logic [CNT_W-1:0]         r_pos;
    logic [CNT_W-1:0]         n_pos;
    logic [CNT_W-1:0]         r_col;
    logic                     r_busy;
    logic                     n_busy;
    logic                     r_drain;
    logic                     n_drain;
    logic                     r_s1_valid;
    logic                     r_s1_close;
    logic signed [DATA_W-1:0] r_s1_x;
    logic                     r_s2_valid;
    logic                     r_s2_close;
    logic                     w_in_acc;
    logic                     w_elem;
    logic                     w_close;
    logic                     w_out_acc;
    logic                     w_last;
    logic                     w_cfg_wr;
    logic                     w_idx_ok;
    logic [2:0]               w_wr_en;
    logic [EIW-1:0]           w_raddr;
    logic [EIW-1:0]           w_waddr;
    t_cell_ctl                w_ctl;
    t_sums                    w_chain [MAX_KEY_DIM+1];

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_embed <= EMBED_RST;
            r_kdim  <= KDIM_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_EMBED:   r_embed <= clamp_count(pwdata[CNT_W-1:0], MAX_EMBED);
                REG_KEY_DIM: r_kdim  <= clamp_count(pwdata[CNT_W-1:0], MAX_KEY_DIM);
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EMBED:   prdata = {{(APB_DW-CNT_W){1'b0}}, r_embed};
            REG_KEY_DIM: prdata = {{(APB_DW-CNT_W){1'b0}}, r_kdim};
            default:     prdata = '0;
        endcase
    end

    // Input acceptance and row position
    assign o_in_stall = r_busy;
    assign w_in_acc   = i_in_valid & ~r_busy;
    assign w_elem     = w_in_acc & (i_in_data.kind == KIND_ELEM);
    assign w_close    = w_elem & (({1'b0, r_pos} + 1'b1) >= {1'b0, r_embed});

    always_comb begin
        n_pos = r_pos;
        if (w_close) begin
            n_pos = '0;
        end else if (w_elem) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Weight write decode; out-of-range indexes are dropped
    assign w_idx_ok = (int'(i_in_data.weight_row) < MAX_EMBED) &&
                      (int'(i_in_data.weight_col) < MAX_KEY_DIM);
    assign w_waddr  = EIW'(i_in_data.weight_row);

    always_comb begin
        w_wr_en = '0;
        if (w_in_acc && i_in_data.kind == KIND_WEIGHT && w_idx_ok) begin
            unique case (i_in_data.matrix_select)
                SEL_QUERY: w_wr_en[WE_Q] = 1'b1;
                SEL_KEY:   w_wr_en[WE_K] = 1'b1;
                SEL_VALUE: w_wr_en[WE_V] = 1'b1;
                SEL_NONE:  w_wr_en = '0;
                default:   w_wr_en = '0;
            endcase
        end
    end

    // Output drain control
    assign w_out_acc = r_drain & ~i_out_stall;
    assign w_last    = ({1'b0, r_col} + 1'b1) == {1'b0, r_kdim};

    always_comb begin
        n_busy  = r_busy;
        n_drain = r_drain;
        if (w_close) begin
            n_busy = 1'b1;
        end else if (w_out_acc && w_last) begin
            n_busy = 1'b0;
        end
        if (r_s2_valid && r_s2_close) begin
            n_drain = 1'b1;
        end else if (w_out_acc && w_last) begin
            n_drain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_busy     <= 1'b0;
            r_drain    <= 1'b0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_close <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_close <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_busy     <= n_busy;
            r_drain    <= n_drain;
            r_s1_valid <= w_elem;
            r_s1_close <= w_close;
            r_s2_valid <= r_s1_valid;
            r_s2_close <= r_s1_close;
            if (r_s2_valid && r_s2_close) begin
                r_col <= '0;
            end else if (w_out_acc) begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Memories read the weight row at the edge that takes the element,
    // so weights and element meet in the product stage
    assign w_raddr = EIW'(r_pos);

    always_ff @(posedge i_clk) begin
        r_s1_x <= i_in_data.x_value;
    end

    // Broadcast to the cells
    always_comb begin
        w_ctl.wr_en   = w_wr_en;
        w_ctl.wr_col  = i_in_data.weight_col;
        w_ctl.wr_data = i_in_data.weight_value;
        w_ctl.x       = r_s1_x;
        w_ctl.acc_en  = r_s2_valid;
        w_ctl.close   = r_s2_close;
        w_ctl.shift   = w_out_acc;
    end

    // Row of column cells; the drain chain flows toward column 0
    assign w_chain[MAX_KEY_DIM] = '0;

    for (genvar j = 0; j < MAX_KEY_DIM; j++) begin : g_cell
        qkv_cell #(.COL(j), .DEPTH(MAX_EMBED), .AW(EIW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_waddr (w_waddr),
            .i_raddr (w_raddr),
            .i_nbr   (w_chain[j+1]),
            .o_sh    (w_chain[j])
        );
    end

    // Output word
    assign o_out_valid          = r_drain;
    assign o_out_data.column    = r_col[IDX_W-1:0];
    assign o_out_data.query_sum = w_chain[0].q;
    assign o_out_data.key_sum   = w_chain[0].k;
    assign o_out_data.value_sum = w_chain[0].v;
    assign o_out_data.last      = w_last;

`ifndef NO_ASSERTIONS
    // Results only while a row is being closed out
    a_drain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> r_busy)
        else $error("output valid outside a busy row");

    // Row close starts the drain at column 0
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_close) |=> (r_drain && r_col == '0))
        else $error("drain did not start at column 0");

    // Column stays below the active key dimension
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_col < r_kdim))
        else $error("column beyond key dimension");

    // Taking the last column ends the drain and frees the input
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last) |=> (!r_drain && !r_busy))
        else $error("drain did not end after last column");
`endif

endmodule

### sv/qkv_ram.sv
`timescale 1ns / 1ps

module qkv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/qkv_cell.sv
`timescale 1ns / 1ps

module qkv_cell
    import qkv_pkg::*;
#(
    parameter int COL   = 0,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic [AW-1:0]   i_waddr,
    input  logic [AW-1:0]   i_raddr,
    input  t_sums           i_nbr,
    output t_sums           o_sh
);

    logic                     w_hit;
    logic signed [DATA_W-1:0] w_wq;
    logic signed [DATA_W-1:0] w_wk;
    logic signed [DATA_W-1:0] w_wv;
    logic signed [PROD_W-1:0] r_pq;
    logic signed [PROD_W-1:0] r_pk;
    logic signed [PROD_W-1:0] r_pv;
    t_sums                    r_acc;
    t_sums                    r_sh;
    t_sums                    n_sum;

    // Weight column of this cell, one memory per matrix
    assign w_hit = (int'(i_ctl.wr_col) == COL);

    qkv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_q (
        .i_clk   (i_clk),
        .i_we    (w_hit & i_ctl.wr_en[WE_Q]),
        .i_waddr (i_waddr),
        .i_wdata (i_ctl.wr_data),
        .i_raddr (i_raddr),
        .o_rdata (w_wq)
    );

    qkv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_k (
        .i_clk   (i_clk),
        .i_we    (w_hit & i_ctl.wr_en[WE_K]),
        .i_waddr (i_waddr),
        .i_wdata (i_ctl.wr_data),
        .i_raddr (i_raddr),
        .o_rdata (w_wk)
    );

    qkv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_v (
        .i_clk   (i_clk),
        .i_we    (w_hit & i_ctl.wr_en[WE_V]),
        .i_waddr (i_waddr),
        .i_wdata (i_ctl.wr_data),
        .i_raddr (i_raddr),
        .o_rdata (w_wv)
    );

    // Products, registered before the add
    always_ff @(posedge i_clk) begin
        r_pq <= w_wq * i_ctl.x;
        r_pk <= w_wk * i_ctl.x;
        r_pv <= w_wv * i_ctl.x;
    end

    // Accumulate, wraps modulo 2^40
    always_comb begin
        n_sum.q = r_acc.q + {{(ACC_W-PROD_W){r_pq[PROD_W-1]}}, r_pq};
        n_sum.k = r_acc.k + {{(ACC_W-PROD_W){r_pk[PROD_W-1]}}, r_pk};
        n_sum.v = r_acc.v + {{(ACC_W-PROD_W){r_pv[PROD_W-1]}}, r_pv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.close ? t_sums'('0) : n_sum;
        end
    end

    // Drain stage: load on row close, else take the neighbor's sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en && i_ctl.close) begin
            r_sh <= n_sum;
        end else if (i_ctl.shift) begin
            r_sh <= i_nbr;
        end
    end

    assign o_sh = r_sh;

endmodule

### dv/qkv_projection_checker.sv
`timescale 1ns / 1ps

// Watches the input, output and APB channels, keeps a shadow copy of the
// weight memories, accumulators and registers, and checks each result word
// against the oldest predicted projection.
module qkv_projection_checker
    import qkv_pkg::*;
#(
    parameter int EMBED_ROWS = 64,
    parameter int KEY_COLS   = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_word          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_word         i_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_mismatches,
    output int                o_outstanding
);

    // Shadow state
    logic signed [DATA_W-1:0] weight_mem [3][EMBED_ROWS*KEY_COLS];
    logic signed [ACC_W-1:0]  q_acc [KEY_COLS];
    logic signed [ACC_W-1:0]  k_acc [KEY_COLS];
    logic signed [ACC_W-1:0]  v_acc [KEY_COLS];
    int                       row_len;
    int                       col_count;
    int                       row_pos;
    t_out_word                projections [$];

    // Zero reads as one, anything above the limit saturates
    function automatic int clamp_len(input logic [CNT_W-1:0] v, input int lim);
        return (v == '0) ? 1 : ((int'(v) > lim) ? lim : int'(v));
    endfunction

    task automatic clear_sums();
        for (int j = 0; j < KEY_COLS; j++) begin
            q_acc[j] = '0;
            k_acc[j] = '0;
            v_acc[j] = '0;
        end
        row_pos = 0;
    endtask

    // Weight write or row element; a closing element queues one word per column
    task automatic absorb_word(input t_in_word w);
        logic signed [DATA_W-1:0] x;
        logic signed [ACC_W-1:0]  pq, pk, pv;
        t_out_word                res;
        int                       base;
        x = w.x_value;
        if (w.kind == KIND_WEIGHT) begin
            if (w.matrix_select != SEL_NONE) begin
                weight_mem[w.matrix_select][int'(w.weight_row) * KEY_COLS
                    + int'(w.weight_col)] = w.weight_value;
            end
        end else begin
            base = ((row_pos >= EMBED_ROWS) ? EMBED_ROWS - 1 : row_pos) * KEY_COLS;
            for (int j = 0; j < KEY_COLS; j++) begin
                pq = x * weight_mem[SEL_QUERY][base + j];
                pk = x * weight_mem[SEL_KEY][base + j];
                pv = x * weight_mem[SEL_VALUE][base + j];
                q_acc[j] = q_acc[j] + pq;
                k_acc[j] = k_acc[j] + pk;
                v_acc[j] = v_acc[j] + pv;
            end
            if (row_pos + 1 < row_len) begin
                row_pos++;
            end else begin
                for (int j = 0; j < col_count; j++) begin
                    res.column    = IDX_W'(j);
                    res.query_sum = q_acc[j];
                    res.key_sum   = k_acc[j];
                    res.value_sum = v_acc[j];
                    res.last      = (j + 1 == col_count);
                    projections.push_back(res);
                end
                clear_sums();
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (got !== want) begin
            o_mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    task automatic take_result(input t_out_word got);
        t_out_word want;
        if (projections.size() == 0) begin
            o_mismatches++;
            $display("%0t: result word with nothing expected, expected none, actual %h",
                     $time, got);
        end else begin
            want = projections.pop_front();
            check_field("column", ACC_W'(want.column), ACC_W'(got.column));
            check_field("query_sum", want.query_sum, got.query_sum);
            check_field("key_sum", want.key_sum, got.key_sum);
            check_field("value_sum", want.value_sum, got.value_sum);
            check_field("last", ACC_W'(want.last), ACC_W'(got.last));
        end
    endtask

    // Sample all three channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_len   = EMBED_ROWS;
            col_count = KEY_COLS;
            clear_sums();
            projections.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_EMBED:   row_len   = clamp_len(pwdata[CNT_W-1:0], EMBED_ROWS);
                    REG_KEY_DIM: col_count = clamp_len(pwdata[CNT_W-1:0], KEY_COLS);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_word(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                take_result(i_out_data);
            end
        end
        o_outstanding = projections.size();
    end

endmodule

### dv/qkv_projection_top_tb.sv
`timescale 1ns / 1ps

// Drives weight loads, embedding rows and register changes into the
// projection block under random valid/stall gaps; the checker scores results.
module qkv_projection_top_tb;
    import qkv_pkg::*;

    localparam int unsigned TIMEOUT_NS = 5_000_000;
    localparam int          SETTLE_CYC = 8;
    // Weight block that rows reach: at most 4 row positions, at most 6 columns
    localparam int          LOAD_ROWS  = 4;
    localparam int          LOAD_COLS  = 6;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in_word          in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_word         out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;

    int in_idle_pct  = 33;
    int out_idle_pct = 72;
    int hold_cycles  = 0;

    qkv_projection_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    qkv_projection_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: long hold-off when requested, else random stall
    initial begin
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("qkv_projection_top_tb failed");
        $finish;
    end

    function automatic t_in_word weight_word(input logic [1:0] sel, input int row,
                                             input int col, input logic [DATA_W-1:0] val);
        t_in_word w;
        w.kind          = KIND_WEIGHT;
        w.matrix_select = sel;
        w.weight_row    = IDX_W'(row);
        w.weight_col    = IDX_W'(col);
        w.weight_value  = val;
        w.x_value       = DATA_W'($urandom);
        return w;
    endfunction

    // Row element; the weight fields carry noise
    function automatic t_in_word elem_word(input logic [DATA_W-1:0] x);
        t_in_word w;
        w.kind          = KIND_ELEM;
        w.matrix_select = 2'($urandom_range(3));
        w.weight_row    = IDX_W'($urandom);
        w.weight_col    = IDX_W'($urandom);
        w.weight_value  = DATA_W'($urandom);
        w.x_value       = x;
        return w;
    endfunction

    // Offer one word after a random gap, hold it until taken
    task automatic send_word(input t_in_word w);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid, wait out every expected word and any work still in flight
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic set_reg(input logic idx, input int unsigned val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_shape(input int unsigned embed, input int unsigned cols);
        drain_results();
        set_reg(REG_EMBED, embed);
        set_reg(REG_KEY_DIM, cols);
    endtask

    // Mostly row elements, some weight rewrites anywhere, matrix select three too
    task automatic send_random(input int n, input int elem_pct);
        t_in_word w;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < elem_pct) begin
                if ($urandom_range(9) == 0) begin
                    w = elem_word(($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff);
                end else begin
                    w = elem_word(DATA_W'($urandom));
                end
            end else begin
                w = weight_word(2'($urandom_range(3)), $urandom_range(63),
                                $urandom_range(63), DATA_W'($urandom));
            end
            send_word(w);
        end
    endtask

    // Every entry that a row can reach gets written in all three matrices
    task automatic preload_weights();
        logic [1:0] mats [3];
        mats = '{SEL_QUERY, SEL_KEY, SEL_VALUE};
        foreach (mats[m]) begin
            for (int r = 0; r < LOAD_ROWS; r++) begin
                for (int c = 0; c < LOAD_COLS; c++) begin
                    send_word(weight_word(mats[m], r, c, DATA_W'($urandom)));
                end
            end
        end
    endtask

    // Change idling with the input channel quiet
    task automatic set_idling(input int in_pct, input int out_pct);
        @(negedge clk);
        in_valid     <= 1'b0;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        preload_weights();

        // Extreme weights and elements on a short row
        set_shape(2, 3);
        send_word(weight_word(SEL_QUERY, 0, 0, 16'h8000));
        send_word(weight_word(SEL_KEY, 0, 1, 16'h7fff));
        send_word(weight_word(SEL_VALUE, 0, 2, 16'h8000));
        send_word(weight_word(SEL_QUERY, 1, 0, 16'h8000));
        send_word(weight_word(SEL_KEY, 1, 1, 16'h8000));
        send_word(weight_word(SEL_VALUE, 1, 2, 16'h7fff));
        send_word(weight_word(SEL_NONE, 0, 0, 16'h7fff));
        send_word(weight_word(SEL_VALUE, 63, 63, 16'h8000));
        send_word(elem_word(16'h8000));
        send_word(elem_word(16'h8000));
        send_word(elem_word(16'h7fff));
        send_word(elem_word(16'h8000));
        // Weight write in the middle of a row
        send_word(elem_word(16'h0001));
        send_word(weight_word(SEL_QUERY, 1, 1, 16'h1234));
        send_word(elem_word(16'hffff));

        // Zero registers read as one
        set_shape(0, 0);
        send_word(elem_word(16'h7fff));

        // Oversized row length saturates, then the row is shortened mid-row
        set_shape(127, LOAD_COLS);
        send_word(elem_word(16'h4000));
        send_word(elem_word(16'h8000));
        send_word(elem_word(16'h7fff));
        drain_results();
        set_reg(REG_EMBED, 2);
        send_word(elem_word(16'hc000));

        set_shape(4, LOAD_COLS);
        send_random(20, 85);

        // Receiver holds off while rows keep coming, then the sender waits it out
        set_shape(3, LOAD_COLS);
        @(posedge clk);
        hold_cycles = 200;
        send_random(9, 100);
        drain_results();

        set_idling(72, 33);
        set_shape(4, 1);
        send_random(15, 90);
        set_shape(1, LOAD_COLS);
        send_random(8, 80);

        set_idling(0, 0);
        set_shape(3, 5);
        send_random(15, 85);
        drain_results();

        if (mismatches == 0) begin
            $display("qkv_projection_top_tb passed");
        end else begin
            $display("qkv_projection_top_tb failed");
        end
        $finish;
    end

endmodule
